// ===== hdl/tlpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants of the two-level page table unit
// request and response structs, command codes, table geometry and flag bits
// ----------------------------------------------------------------------------
package tlpt_pkg;

  // fixed geometry of the i386 walk
  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int DIR_AW        = 10;
  localparam int TAB_IW        = 10;
  localparam int PAGE_OFF_W    = 12;
  localparam int PAGE_NUM_W    = 20;
  localparam int DIR_W         = 23;
  localparam int TNO_W         = 11;

  // default pool size
  localparam int POOL_TABLES_DEF = 16;

  // flag bits
  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_USER_BIT    = 2;
  localparam logic [PAGE_OFF_W-1:0] FLAG_PRESENT = 12'h001;
  localparam logic [PAGE_OFF_W-1:0] FLAG_WRITE   = 12'h002;

  localparam logic [20:0] MAX_PAGES = 21'd1048576;

  typedef enum logic [1:0] {
    CMD_MAP     = 2'd0,
    CMD_UNMAP   = 2'd1,
    CMD_RESOLVE = 2'd2,
    CMD_RANGE   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] entry_flags;
    logic [31:0] range_length;
  } tlpt_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] resolved_addr;
    logic [20:0] mapped_count;
    logic [10:0] table_count;
  } tlpt_rsp_t;

endpackage

// ===== hdl/two_level_page_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_unit: page directory and pooled page tables
// map, unmap, resolve and user/present range check over a two-level walk
// ----------------------------------------------------------------------------
// timing: map, unmap and resolve answer from S_CHK, or from S_TAB when the directory
//   read settles it; a range check passes through S_TAB and S_CHK for each page walked
// one request at a time: a new one is taken only back in S_IDLE, after the dependent
//   registered directory and table reads; a held response stalls the input
// reset: synchronous, active low; after reset a clearing pass zeroes both
//   memories, during which no request is taken
module two_level_page_table_unit #(
  parameter int POOL_TABLES = tlpt_pkg::POOL_TABLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlpt_pkg::tlpt_req_t in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output tlpt_pkg::tlpt_rsp_t out_rsp
);

  localparam int TAB_DEPTH = POOL_TABLES * tlpt_pkg::TABLE_ENTRIES;
  localparam int TBL_AW    = $clog2(TAB_DEPTH);

  typedef enum logic [2:0] {
    S_CLR,   // clearing pass after reset
    S_IDLE,  // waiting for a request, directory read issued from the port
    S_TAB,   // directory entry available, table read issued
    S_CHK,   // page entry available, written back by map and unmap
    S_DONE   // result parked until the output register frees up
  } state_t;

  // ---------------------------------------------------------------------------
  // memories: directory and table pool, registered read
  // ---------------------------------------------------------------------------
  logic [tlpt_pkg::DIR_W-1:0] dir_mem [tlpt_pkg::DIR_ENTRIES];
  logic [31:0]                tab_mem [TAB_DEPTH];

  logic [tlpt_pkg::DIR_AW-1:0] dir_ra, dir_wa;
  logic [tlpt_pkg::DIR_W-1:0]  dir_wd;
  logic                        dir_we;
  logic [TBL_AW-1:0]           tab_ra, tab_wa;
  logic [31:0]                 tab_wd;
  logic                        tab_we;
  logic [tlpt_pkg::DIR_W-1:0]  dir_q_r;
  logic [31:0]                 tab_q_r;

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    dir_q_r <= dir_mem[dir_ra];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    tab_q_r <= tab_mem[tab_ra];
  end

  // ---------------------------------------------------------------------------
  // control and request registers
  // ---------------------------------------------------------------------------
  state_t                          state_r, state_nxt;
  logic [TBL_AW-1:0]               clr_r, clr_nxt;
  tlpt_pkg::cmd_t                  cmd_r, cmd_nxt;
  logic [tlpt_pkg::PAGE_NUM_W-1:0] va_pg_r, va_pg_nxt;     // page being walked
  logic [tlpt_pkg::PAGE_OFF_W-1:0] va_off_r, va_off_nxt;
  logic [tlpt_pkg::PAGE_NUM_W-1:0] pa_frame_r, pa_frame_nxt;
  logic [tlpt_pkg::PAGE_OFF_W-1:0] flags_r, flags_nxt;
  logic [31:0]                     end_r, end_nxt;         // range end, page aligned
  logic                            pre_fail_r, pre_fail_nxt;
  logic                            in_rng_r, in_rng_nxt;   // first page below the end
  logic [TBL_AW-1:0]               loc_r, loc_nxt;         // page entry address
  logic [20:0]                     pages_r, pages_nxt;
  logic [10:0]                     tables_r, tables_nxt;
  logic                            out_valid_r, out_valid_nxt;
  tlpt_pkg::tlpt_rsp_t             out_rsp_r, out_rsp_nxt;
  logic                            res_ok_r, res_ok_nxt;
  logic [31:0]                     res_addr_r, res_addr_nxt;

  // ---------------------------------------------------------------------------
  // decode of the directory and page entries
  // ---------------------------------------------------------------------------
  logic [tlpt_pkg::TNO_W-1:0] de_tno;
  logic                       de_valid;
  logic                       de_user;
  logic                       pe_present;
  logic                       pe_user;
  logic                       need_user;
  logic [20:0]                loc_full;
  logic [20:0]                new_loc_full;
  logic [tlpt_pkg::PAGE_NUM_W-1:0] nxt_pg;
  logic                       nxt_in_rng;
  logic                       out_free;

  assign de_tno     = dir_q_r[tlpt_pkg::DIR_W-1:tlpt_pkg::PAGE_OFF_W];
  // a table number outside the pool counts as absent
  assign de_valid   = dir_q_r[tlpt_pkg::FLAG_PRESENT_BIT]
                      && (de_tno < tlpt_pkg::TNO_W'(POOL_TABLES));
  assign de_user    = dir_q_r[tlpt_pkg::FLAG_USER_BIT];
  assign pe_present = tab_q_r[tlpt_pkg::FLAG_PRESENT_BIT];
  assign pe_user    = tab_q_r[tlpt_pkg::FLAG_USER_BIT];
  assign need_user  = flags_r[tlpt_pkg::FLAG_USER_BIT];

  // table address = table number * 1024 + slot
  assign loc_full     = {de_tno, va_pg_r[tlpt_pkg::TAB_IW-1:0]};
  assign new_loc_full = {tables_r, va_pg_r[tlpt_pkg::TAB_IW-1:0]};

  assign nxt_pg     = va_pg_r + tlpt_pkg::PAGE_NUM_W'(1);
  assign nxt_in_rng = {nxt_pg, {tlpt_pkg::PAGE_OFF_W{1'b0}}} < end_r;

  // output register can take a new response this cycle
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // request pre-checks, worked out as the request is taken
  // ---------------------------------------------------------------------------
  logic [31:0] req_end_sum;
  logic [31:0] req_end;
  logic        req_unaligned_va;
  logic        req_unaligned_pa;

  assign req_end_sum      = in_req.virt_addr + in_req.range_length + 32'h0000_0FFF;
  assign req_end          = {req_end_sum[31:12], {tlpt_pkg::PAGE_OFF_W{1'b0}}};
  assign req_unaligned_va = |in_req.virt_addr[tlpt_pkg::PAGE_OFF_W-1:0];
  assign req_unaligned_pa = |in_req.phys_addr[tlpt_pkg::PAGE_OFF_W-1:0];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  logic        fin;
  logic        fin_ok;
  logic [31:0] fin_addr;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    va_pg_nxt     = va_pg_r;
    va_off_nxt    = va_off_r;
    pa_frame_nxt  = pa_frame_r;
    flags_nxt     = flags_r;
    end_nxt       = end_r;
    pre_fail_nxt  = pre_fail_r;
    in_rng_nxt    = in_rng_r;
    loc_nxt       = loc_r;
    pages_nxt     = pages_r;
    tables_nxt    = tables_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_rsp_nxt   = out_rsp_r;
    res_ok_nxt    = res_ok_r;
    res_addr_nxt  = res_addr_r;

    fin      = 1'b0;
    fin_ok   = 1'b0;
    fin_addr = 32'd0;

    dir_we = 1'b0;
    dir_wa = va_pg_r[tlpt_pkg::PAGE_NUM_W-1:tlpt_pkg::TAB_IW];
    dir_wd = '0;
    tab_we = 1'b0;
    tab_wa = loc_r;
    tab_wd = 32'd0;

    // directory read: from the port when idle, the next page while a range walks on
    unique case (state_r)
      S_IDLE:  dir_ra = in_req.virt_addr[31:22];
      S_CHK:   dir_ra = nxt_pg[tlpt_pkg::PAGE_NUM_W-1:tlpt_pkg::TAB_IW];
      default: dir_ra = va_pg_r[tlpt_pkg::PAGE_NUM_W-1:tlpt_pkg::TAB_IW];
    endcase
    tab_ra = loc_full[TBL_AW-1:0];

    unique case (state_r)
      S_CLR: begin
        dir_we  = 1'b1;
        dir_wa  = clr_r[tlpt_pkg::DIR_AW-1:0];
        tab_we  = 1'b1;
        tab_wa  = clr_r;
        clr_nxt = clr_r + TBL_AW'(1);
        if (clr_r == TBL_AW'(TAB_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt      = in_req.cmd;
          va_pg_nxt    = in_req.virt_addr[31:12];
          va_off_nxt   = in_req.virt_addr[tlpt_pkg::PAGE_OFF_W-1:0];
          pa_frame_nxt = in_req.phys_addr[31:12];
          flags_nxt    = in_req.entry_flags;
          end_nxt      = req_end;
          in_rng_nxt   = {in_req.virt_addr[31:12], {tlpt_pkg::PAGE_OFF_W{1'b0}}} < req_end;
          unique case (in_req.cmd)
            tlpt_pkg::CMD_MAP:     pre_fail_nxt = req_unaligned_va || req_unaligned_pa;
            tlpt_pkg::CMD_UNMAP:   pre_fail_nxt = req_unaligned_va;
            tlpt_pkg::CMD_RESOLVE: pre_fail_nxt = 1'b0;
            tlpt_pkg::CMD_RANGE:   pre_fail_nxt = (in_req.range_length == 32'd0)
                                                  || (req_end < in_req.virt_addr);
          endcase
          state_nxt = S_TAB;
        end
      end

      S_TAB: begin
        loc_nxt = loc_full[TBL_AW-1:0];
        unique case (cmd_r)
          tlpt_pkg::CMD_MAP: begin
            if (pre_fail_r) begin
              fin = 1'b1;
            end else if (de_valid) begin
              state_nxt = S_CHK;
            end else if (tables_r >= tlpt_pkg::TNO_W'(POOL_TABLES)) begin
              fin = 1'b1;  // pool exhausted
            end else begin
              // new table: still zero since the clearing pass, so the page is free
              dir_we     = 1'b1;
              dir_wd     = {tables_r, flags_r | tlpt_pkg::FLAG_WRITE | tlpt_pkg::FLAG_PRESENT};
              tab_we     = 1'b1;
              tab_wa     = new_loc_full[TBL_AW-1:0];
              tab_wd     = {pa_frame_r, flags_r | tlpt_pkg::FLAG_PRESENT};
              tables_nxt = tables_r + 11'd1;
              if (pages_r < tlpt_pkg::MAX_PAGES) begin
                pages_nxt = pages_r + 21'd1;
              end
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
          end
          tlpt_pkg::CMD_UNMAP, tlpt_pkg::CMD_RESOLVE: begin
            if (pre_fail_r || !de_valid) begin
              fin = 1'b1;
            end else begin
              state_nxt = S_CHK;
            end
          end
          tlpt_pkg::CMD_RANGE: begin
            if (pre_fail_r) begin
              fin = 1'b1;
            end else if (!in_rng_r) begin
              fin    = 1'b1;  // empty walk passes
              fin_ok = 1'b1;
            end else if (!de_valid || (need_user && !de_user)) begin
              fin = 1'b1;
            end else begin
              state_nxt = S_CHK;
            end
          end
        endcase
      end

      S_CHK: begin
        unique case (cmd_r)
          tlpt_pkg::CMD_MAP: begin
            fin = 1'b1;
            if (!pe_present) begin
              tab_we = 1'b1;
              tab_wd = {pa_frame_r, flags_r | tlpt_pkg::FLAG_PRESENT};
              if (pages_r < tlpt_pkg::MAX_PAGES) begin
                pages_nxt = pages_r + 21'd1;
              end
              fin_ok = 1'b1;
            end
          end
          tlpt_pkg::CMD_UNMAP: begin
            fin = 1'b1;
            if (pe_present) begin
              tab_we = 1'b1;
              if (pages_r != 21'd0) begin
                pages_nxt = pages_r - 21'd1;
              end
              fin_ok = 1'b1;
            end
          end
          tlpt_pkg::CMD_RESOLVE: begin
            fin = 1'b1;
            if (pe_present) begin
              fin_ok   = 1'b1;
              fin_addr = {tab_q_r[31:12], va_off_r};
            end
          end
          tlpt_pkg::CMD_RANGE: begin
            if (!pe_present || (need_user && !pe_user)) begin
              fin = 1'b1;
            end else if ((&va_pg_r) || !nxt_in_rng) begin
              fin    = 1'b1;  // last page of the range or of the address space
              fin_ok = 1'b1;
            end else begin
              va_pg_nxt = nxt_pg;
              state_nxt = S_TAB;
            end
          end
        endcase
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = '{ok: res_ok_r, resolved_addr: res_addr_r,
                            mapped_count: pages_r, table_count: tables_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // hand the result over, or park it while the previous response is still held
    if (fin) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '{ok: fin_ok, resolved_addr: fin_addr,
                          mapped_count: pages_nxt, table_count: tables_nxt};
        state_nxt     = S_IDLE;
      end else begin
        res_ok_nxt   = fin_ok;
        res_addr_nxt = fin_addr;
        state_nxt    = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pages_r     <= 21'd0;
      tables_r    <= 11'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pages_r     <= pages_nxt;
      tables_r    <= tables_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    va_pg_r    <= va_pg_nxt;
    va_off_r   <= va_off_nxt;
    pa_frame_r <= pa_frame_nxt;
    flags_r    <= flags_nxt;
    end_r      <= end_nxt;
    pre_fail_r <= pre_fail_nxt;
    in_rng_r   <= in_rng_nxt;
    loc_r      <= loc_nxt;
    out_rsp_r  <= out_rsp_nxt;
    res_ok_r   <= res_ok_nxt;
    res_addr_r <= res_addr_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // pool allocation never runs past the configured pool
  a_tables_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tables_r <= tlpt_pkg::TNO_W'(POOL_TABLES))
    else $error("table count beyond pool size");

  // tables are never freed and at most one is allocated per request
  a_tables_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (tables_r == $past(tables_r)) || (tables_r == $past(tables_r) + 11'd1))
    else $error("table count moved by more than one or went down");

  // the page count moves by at most one per cycle
  a_pages_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (pages_r == $past(pages_r)) || (pages_r == $past(pages_r) + 21'd1)
                     || (pages_r == $past(pages_r) - 21'd1))
    else $error("page count jumped");

  // counts change only in the cycles that commit a map or unmap
  a_count_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && ($past(state_r) != S_TAB) && ($past(state_r) != S_CHK)
    |-> $stable(pages_r) && $stable(tables_r))
    else $error("count changed outside a walk");

endmodule
